// ----- rtl/bbmo_pkg.sv -----
// Shared constants and codes for the billboard matrix orientation block.
// No dependencies; imported by billboard_matrix_orient, bbmo_checker and tb.
package bbmo_pkg;

    localparam int IN_W          = 24;               // Q8.16 element
    localparam int OUT_W         = 32;               // Q16.16 element
    localparam int SQ_W          = 2 * IN_W - 1;     // one square, unsigned
    localparam int SUM_W         = 2 * IN_W;         // sum of three squares
    localparam int LEN_W         = IN_W;             // floor sqrt of the sum
    localparam int REM_W         = LEN_W + 2;        // sqrt remainder
    localparam int BITS_PER_STG  = 2;                // root bits per sqrt stage
    localparam int SQRT_STAGES   = LEN_W / BITS_PER_STG;
    localparam int PIPE_DEPTH    = SQRT_STAGES + 4;  // stages ahead of the output
    localparam int PROD_W        = 2 * IN_W;         // one camera product
    localparam int LEFT_W        = PROD_W + 1 - 16;  // cross product in Q.16
    localparam int LO_W          = 17;               // low split of left
    localparam int HI_W          = LEFT_W - LO_W;    // high split of left
    localparam int PART_W        = HI_W + LEN_W + 1; // one partial product
    localparam int WIDE_W        = PART_W + LO_W;    // recombined product
    localparam int SAT_W         = WIDE_W - 16;      // after the Q.16 truncation
    localparam int DIRP_W        = IN_W + LEN_W + 1; // vector times length
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_CAMERA = 2'd1,
        MODE_ZAXIS  = 2'd2,
        MODE_ODD    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_DIR_X = 3'd1,
        REG_DIR_Y = 3'd2,
        REG_DIR_Z = 3'd3,
        REG_UP_X  = 3'd4,
        REG_UP_Y  = 3'd5,
        REG_UP_Z  = 3'd6,
        REG_NONE  = 3'd7
    } reg_idx_t;

endpackage

// ----- rtl/billboard_matrix_orient.sv -----
// Billboard orientation of a 3x3 entity matrix that keeps the column scale.
// Depends on bbmo_pkg (widths, facing modes, register indexes).
//
// Usage:
//   Input channel: in_valid / in_stall with nine Q8.16 elements in_rR_cC.
//   Output channel: out_valid / out_stall with nine Q16.16 elements out_rR_cC.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 is the facing mode, 1..3 the camera direction,
//   4..6 the camera up vector. Write only while no item is in flight.
// Throughput: one item per cycle while out_stall does not hold a result, with no bubbles.
// Pipeline from the accepting edge to out_valid: the capture register and two
//   more stages form the squares and the column sums, twelve stages take the
//   floor square root two root bits at a time, one stage multiplies the camera
//   vectors by the lengths and the output register truncates, saturates and
//   picks the mode.
// The camera cross product sits in its own two-stage path fed from the
//   configuration registers, so it is settled long before any item needs it.
// Reset: all valid bits clear, facing mode returns to camera, camera vectors
//   to zero (rebuilt columns then read as zero).
// Stall: the whole pipeline holds while a result waits under out_stall; the
//   input stalls in the same cycle, so no item is dropped or repeated.
module billboard_matrix_orient
    import bbmo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [IN_W-1:0]          cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [IN_W-1:0]   in_r0_c0,
    input  logic signed [IN_W-1:0]   in_r1_c0,
    input  logic signed [IN_W-1:0]   in_r2_c0,
    input  logic signed [IN_W-1:0]   in_r0_c1,
    input  logic signed [IN_W-1:0]   in_r1_c1,
    input  logic signed [IN_W-1:0]   in_r2_c1,
    input  logic signed [IN_W-1:0]   in_r0_c2,
    input  logic signed [IN_W-1:0]   in_r1_c2,
    input  logic signed [IN_W-1:0]   in_r2_c2,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  out_r0_c0,
    output logic signed [OUT_W-1:0]  out_r1_c0,
    output logic signed [OUT_W-1:0]  out_r2_c0,
    output logic signed [OUT_W-1:0]  out_r0_c1,
    output logic signed [OUT_W-1:0]  out_r1_c1,
    output logic signed [OUT_W-1:0]  out_r2_c1,
    output logic signed [OUT_W-1:0]  out_r0_c2,
    output logic signed [OUT_W-1:0]  out_r1_c2,
    output logic signed [OUT_W-1:0]  out_r2_c2
);

    // Square-root working state carried down the sqrt stages
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] root;
        logic [SUM_W-1:0] rest;
    } sqst_t;

    // Two digit-by-digit steps of the integer square root
    function automatic sqst_t sqrt_step(input sqst_t s);
        sqst_t          r;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        r = s;
        for (int k = 0; k < BITS_PER_STG; k++)
        begin
            cur   = {r.rem, r.rest[SUM_W-1 -: 2]};
            trial = {2'b00, r.root, 2'b01};
            r.rest = {r.rest[SUM_W-3:0], 2'b00};
            if (cur >= trial)
            begin
                cur    = cur - trial;
                r.root = {r.root[LEN_W-2:0], 1'b1};
            end
            else
            begin
                r.root = {r.root[LEN_W-2:0], 1'b0};
            end
            r.rem = cur[REM_W-1:0];
        end
        return r;
    endfunction

    // Clamp to the signed output range
    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
        lo = -hi - SAT_W'(1);
        if (x > hi)
            return {1'b0, {(OUT_W-1){1'b1}}};
        else if (x < lo)
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return x[OUT_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    mode_t                   mode_reg;
    logic signed [IN_W-1:0]  dir_reg [3];
    logic signed [IN_W-1:0]  up_reg  [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CAMERA;
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= '0;
                up_reg[i]  <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:  mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_DIR_X: dir_reg[0] <= cfg_data;
                REG_DIR_Y: dir_reg[1] <= cfg_data;
                REG_DIR_Z: dir_reg[2] <= cfg_data;
                REG_UP_X:  up_reg[0]  <= cfg_data;
                REG_UP_Y:  up_reg[1]  <= cfg_data;
                REG_UP_Z:  up_reg[2]  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Cross product left = dir x up: products, then difference truncated to Q.16
    logic signed [PROD_W-1:0] cpa_reg  [3];
    logic signed [PROD_W-1:0] cpb_reg  [3];
    logic signed [LEFT_W-1:0] left_reg [3];
    logic signed [PROD_W:0]   cdiff    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cdiff[i] = (PROD_W+1)'(cpa_reg[i]) - (PROD_W+1)'(cpb_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cpa_reg[i]  <= dir_reg[(i+1)%3] * up_reg[(i+2)%3];
            cpb_reg[i]  <= dir_reg[(i+2)%3] * up_reg[(i+1)%3];
            left_reg[i] <= cdiff[i][PROD_W:16];
        end
    end

    // ---------------- item pipeline ----------------
    logic                    adv;
    logic [PIPE_DEPTH-1:0]   v_reg;
    logic                    out_valid_reg;
    logic signed [IN_W-1:0]  m_reg   [PIPE_DEPTH][9];
    logic [SQ_W-1:0]         sq_reg  [9];
    logic [SUM_W-1:0]        sum_reg [3];
    sqst_t                   sq_st_reg [SQRT_STAGES][3];
    logic signed [PART_W-1:0] ph_reg [3];
    logic [PART_W-1:0]        pl_reg [3];
    logic signed [DIRP_W-1:0] pd_reg [3];
    logic signed [DIRP_W-1:0] pu_reg [3];
    logic [LEN_W-1:0]         len1_reg;
    logic signed [OUT_W-1:0]  out_reg [9];
    logic signed [OUT_W-1:0]  out_next [9];
    logic signed [IN_W-1:0]   in_m [9];
    sqst_t                    sq_first [3];
    logic [LEN_W-1:0]         len_last [3];
    logic signed [LEN_W:0]    len_s [3];
    logic signed [2*IN_W-1:0] sq_full [9];
    logic [PART_W-1:0]        pl_full [3];

    // Advance everything unless a finished result is held by the receiver
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    assign in_m = '{in_r0_c0, in_r1_c0, in_r2_c0,
                    in_r0_c1, in_r1_c1, in_r2_c1,
                    in_r0_c2, in_r1_c2, in_r2_c2};

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            sq_full[i] = m_reg[0][i] * m_reg[0][i];
        for (int c = 0; c < 3; c++)
        begin
            sq_first[c] = sqrt_step('{rem: '0, root: '0, rest: sum_reg[c]});
            len_last[c] = sq_st_reg[SQRT_STAGES-1][c].root;
            len_s[c]    = $signed({1'b0, len_last[c]});
        end
        for (int i = 0; i < 3; i++)
            pl_full[i] = left_reg[i][LO_W-1:0] * len_last[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[PIPE_DEPTH-2:0], in_valid};
            out_valid_reg <= v_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // capture
            m_reg[0] <= in_m;
            for (int s = 1; s < PIPE_DEPTH; s++)
                m_reg[s] <= m_reg[s-1];
            // squares
            for (int i = 0; i < 9; i++)
                sq_reg[i] <= sq_full[i][SQ_W-1:0];
            // column sums
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= SUM_W'(sq_reg[3*c]) + SUM_W'(sq_reg[3*c+1])
                              + SUM_W'(sq_reg[3*c+2]);
            // square root, two root bits per stage
            for (int c = 0; c < 3; c++)
            begin
                sq_st_reg[0][c] <= sq_first[c];
                for (int s = 1; s < SQRT_STAGES; s++)
                    sq_st_reg[s][c] <= sqrt_step(sq_st_reg[s-1][c]);
            end
            // scale by the lengths; left splits into two partial products
            for (int i = 0; i < 3; i++)
            begin
                ph_reg[i] <= $signed(left_reg[i][LEFT_W-1:LO_W]) * len_s[0];
                pl_reg[i] <= pl_full[i];
                pd_reg[i] <= dir_reg[i] * len_s[2];
                pu_reg[i] <= up_reg[i] * len_s[1];
            end
            len1_reg <= len_last[1];
            out_reg  <= out_next;
        end
    end

    // Output stage: recombine, truncate to Q.16, saturate, select by mode
    logic signed [WIDE_W-1:0] wide [3];
    logic signed [OUT_W-1:0]  col0 [3];
    logic signed [OUT_W-1:0]  col1 [3];
    logic signed [OUT_W-1:0]  col2 [3];
    logic signed [IN_W-1:0]   mo [9];

    always_comb
    begin
        mo = m_reg[PIPE_DEPTH-1];
        for (int i = 0; i < 3; i++)
        begin
            wide[i] = $signed({ph_reg[i], {LO_W{1'b0}}})
                      + $signed({{LO_W{1'b0}}, pl_reg[i]});
            col0[i] = sat(wide[i][WIDE_W-1:16]);
            col2[i] = sat(SAT_W'($signed(pd_reg[i][DIRP_W-1:16])));
            col1[i] = sat(SAT_W'($signed(pu_reg[i][DIRP_W-1:16])));
        end
        for (int i = 0; i < 9; i++)
            out_next[i] = OUT_W'(mo[i]);
        unique case (mode_reg)
            MODE_FREE:
            begin
            end
            MODE_CAMERA:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    out_next[i]   = col0[i];
                    out_next[3+i] = col1[i];
                    out_next[6+i] = col2[i];
                end
            end
            MODE_ZAXIS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    out_next[i]   = col0[i];
                    out_next[6+i] = col2[i];
                end
                out_next[3] = '0;
                out_next[4] = $signed({{(OUT_W-LEN_W){1'b0}}, len1_reg});
                out_next[5] = '0;
            end
            default:
            begin
                // unused code: rebuild outer columns, pass the middle one
                for (int i = 0; i < 3; i++)
                begin
                    out_next[i]   = col0[i];
                    out_next[6+i] = col2[i];
                end
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_r0_c0 = out_reg[0];
    assign out_r1_c0 = out_reg[1];
    assign out_r2_c0 = out_reg[2];
    assign out_r0_c1 = out_reg[3];
    assign out_r1_c1 = out_reg[4];
    assign out_r2_c1 = out_reg[5];
    assign out_r0_c2 = out_reg[6];
    assign out_r1_c2 = out_reg[7];
    assign out_r2_c2 = out_reg[8];

`ifndef SYNTH
    // an empty output register never holds back the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty output");

    // an accepted item occupies the first stage next cycle
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted item not captured");

    // z-axis mode clears the side terms of the middle column
    a_zaxis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mode_reg == MODE_ZAXIS && $past(adv))
            |-> (out_reg[3] == '0 && out_reg[5] == '0))
        else $error("z-axis column 1 side terms not zero");
`endif

endmodule

// ----- tb/bbmo_checker.sv -----
// Checker for billboard_matrix_orient: follows the register writes, predicts
// each accepted item and compares every result field in order.
// Depends on bbmo_pkg for widths, facing modes and register indexes.
module bbmo_checker
    import bbmo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [IN_W-1:0]           cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [8:0][IN_W-1:0]      in_mat,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [8:0][OUT_W-1:0]     out_mat,
    output int                        errors,
    output int                        pending
);

    typedef logic [8:0][OUT_W-1:0] res_mat_t;

    mode_t              mode_q;
    longint             dir_q [3];
    longint             up_q  [3];
    res_mat_t           expected_mats [$];

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [OUT_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[OUT_W-1:0];
    endfunction

    function automatic longint col_length(longint a, longint b, longint c);
        return longint'(floor_sqrt(longint'(a * a + b * b + c * c)));
    endfunction

    // Rebuild the orientation from the camera registers, keep the column scale; free mode passes the matrix through.
    function automatic res_mat_t orient_matrix(logic [8:0][IN_W-1:0] m_in);
        longint   m [9];
        longint   side [3];
        longint   len0, len1, len2;
        res_mat_t r;
        for (int i = 0; i < 9; i++)
            m[i] = longint'($signed(m_in[i]));
        if (mode_q == MODE_FREE)
        begin
            for (int i = 0; i < 9; i++)
                r[i] = clamp32(m[i]);
            return r;
        end
        len0 = col_length(m[0], m[1], m[2]);
        len1 = col_length(m[3], m[4], m[5]);
        len2 = col_length(m[6], m[7], m[8]);
        side[0] = (dir_q[1] * up_q[2] - dir_q[2] * up_q[1]) >>> 16;
        side[1] = (dir_q[2] * up_q[0] - dir_q[0] * up_q[2]) >>> 16;
        side[2] = (dir_q[0] * up_q[1] - dir_q[1] * up_q[0]) >>> 16;
        for (int i = 0; i < 3; i++)
        begin
            r[i]     = clamp32((side[i] * len0) >>> 16);
            r[6 + i] = clamp32((dir_q[i] * len2) >>> 16);
        end
        case (mode_q)
            MODE_CAMERA:
                for (int i = 0; i < 3; i++)
                    r[3 + i] = clamp32((up_q[i] * len1) >>> 16);
            MODE_ZAXIS:
            begin
                r[3] = '0;
                r[4] = clamp32(len1);
                r[5] = '0;
            end
            default:
                for (int i = 3; i < 6; i++)
                    r[i] = clamp32(m[i]);
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_mat_t want;
        int       bad;
        if (!rst_n)
        begin
            mode_q  <= MODE_CAMERA;
            for (int i = 0; i < 3; i++)
            begin
                dir_q[i] <= 0;
                up_q[i]  <= 0;
            end
            errors  <= 0;
            pending <= 0;
            expected_mats.delete();
        end
        else
        begin
            bad = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:  mode_q   <= mode_t'(cfg_data[1:0]);
                    REG_DIR_X: dir_q[0] <= longint'($signed(cfg_data));
                    REG_DIR_Y: dir_q[1] <= longint'($signed(cfg_data));
                    REG_DIR_Z: dir_q[2] <= longint'($signed(cfg_data));
                    REG_UP_X:  up_q[0]  <= longint'($signed(cfg_data));
                    REG_UP_Y:  up_q[1]  <= longint'($signed(cfg_data));
                    REG_UP_Z:  up_q[2]  <= longint'($signed(cfg_data));
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_mats.push_back(orient_matrix(in_mat));
            if (out_valid && !out_stall)
            begin
                if (expected_mats.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %h", $time, out_mat);
                    bad = bad + 1;
                end
                else
                begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (want[i] !== out_mat[i])
                        begin
                            $display("%0t: element r%0d_c%0d expected %h got %h",
                                     $time, i % 3, i / 3, want[i], out_mat[i]);
                            bad = bad + 1;
                        end
                end
            end
            errors  <= errors + bad;
            pending <= expected_mats.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the billboard_matrix_orient testbench: clock, reset, stimulus,
// idling and the verdict. Depends on bbmo_pkg, billboard_matrix_orient and bbmo_checker.
module tb;
    import bbmo_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles with nothing moving
    localparam int LONG_HOLD   = 80;    // receiver hold-off, well past the pipe depth

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [IN_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [8:0][IN_W-1:0] in_mat;
    logic out_valid;
    logic out_stall;
    logic [8:0][OUT_W-1:0] out_mat;
    int errors;
    int pending;

    int sender_idle_pct;
    int recv_stall_pct;
    logic hold_req;
    int hold_left;
    logic hold_done;
    int quiet_cycles;

    billboard_matrix_orient DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .in_r0_c0(in_mat[0]), .in_r1_c0(in_mat[1]), .in_r2_c0(in_mat[2]),
        .in_r0_c1(in_mat[3]), .in_r1_c1(in_mat[4]), .in_r2_c1(in_mat[5]),
        .in_r0_c2(in_mat[6]), .in_r1_c2(in_mat[7]), .in_r2_c2(in_mat[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_r0_c0(out_mat[0]), .out_r1_c0(out_mat[1]), .out_r2_c0(out_mat[2]),
        .out_r0_c1(out_mat[3]), .out_r1_c1(out_mat[4]), .out_r2_c1(out_mat[5]),
        .out_r0_c2(out_mat[6]), .out_r1_c2(out_mat[7]), .out_r2_c2(out_mat[8])
    );

    bbmo_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_mat(in_mat),
        .out_valid(out_valid), .out_stall(out_stall), .out_mat(out_mat),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls at the phase's rate; one long hold-off when
    // asked, counted here so the sender keeps pushing and the pipe backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: give up once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("billboard_matrix_orient regression: fail");
            $finish;
        end
    end

    task automatic cfg_write(reg_idx_t idx, logic [IN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the item until the block takes it; stall only changes after an edge.
    // Entered at a rising edge; returns at the accepting edge with in_valid
    // still high, so the next item can follow without a gap.
    task automatic push_matrix(logic [8:0][IN_W-1:0] m);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mat   <= m;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_element();
        logic [IN_W-1:0] v;
        v = $urandom();
        case ($urandom_range(4))
            0: v = $signed(v) >>> 12;             // tiny, near zero
            1: v = $signed(v) >>> 5;              // around unity scale
            2: v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_random(int count);
        logic [8:0][IN_W-1:0] m;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = rand_element();
            push_matrix(m);
        end
    endtask

    // Field extremes, unit columns and one column at a time at full scale.
    task automatic push_directed();
        logic [8:0][IN_W-1:0] m;
        m = '0;
        push_matrix(m);
        m = {9{24'h7FFFFF}};
        push_matrix(m);
        m = {9{24'h800000}};
        push_matrix(m);
        m = {24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
             24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF};
        push_matrix(m);
        m = '0;
        m[0] = 24'h010000;
        m[4] = 24'h010000;
        m[8] = 24'h010000;
        push_matrix(m);
        m = {9{24'hFFFFFF}};
        push_matrix(m);
        for (int c = 0; c < 3; c++)
        begin
            m = '0;
            m[3 * c] = 24'h800000;
            m[3 * c + 1] = 24'h7FFFFF;
            m[3 * c + 2] = 24'h800000;
            push_matrix(m);
        end
    endtask

    task automatic set_camera(mode_t mode, logic [IN_W-1:0] dx, logic [IN_W-1:0] dy,
                              logic [IN_W-1:0] dz, logic [IN_W-1:0] ux,
                              logic [IN_W-1:0] uy, logic [IN_W-1:0] uz);
        cfg_write(REG_MODE, IN_W'(mode));
        cfg_write(REG_DIR_X, dx);
        cfg_write(REG_DIR_Y, dy);
        cfg_write(REG_DIR_Z, dz);
        cfg_write(REG_UP_X, ux);
        cfg_write(REG_UP_Y, uy);
        cfg_write(REG_UP_Z, uz);
    endtask

    // Drop the input, then drain before touching registers.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_mat = '0;
        hold_req = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state: camera mode with zero vectors, rebuilt columns read zero.
        set_idling(0);
        push_directed();
        push_random(40);
        drain();

        // Camera mode with random vectors; long receiver hold-off midway.
        set_camera(MODE_CAMERA, rand_element(), rand_element(), rand_element(),
                   rand_element(), rand_element(), rand_element());
        set_idling(1);
        push_random(20);
        set_idling(0);
        hold_req <= 1'b1;
        push_random(40);
        drain();

        // Free mode passes everything through.
        cfg_write(REG_MODE, IN_W'(MODE_FREE));
        set_idling(2);
        push_directed();
        push_random(45);
        drain();

        // Z-axis mode; the sender stops once until the pipe is empty.
        set_camera(MODE_ZAXIS, rand_element(), rand_element(), rand_element(),
                   rand_element(), rand_element(), rand_element());
        set_idling(3);
        push_random(25);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        push_random(25);
        drain();

        // Undefined mode: outer columns rebuilt, middle one passed through.
        cfg_write(REG_MODE, IN_W'(MODE_ODD));
        cfg_write(REG_NONE, 24'h5A5A5A);
        set_idling(0);
        push_directed();
        push_random(40);
        drain();

        // Largest camera vectors; being antiparallel, they give a zero first column.
        set_camera(MODE_CAMERA, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                   24'h800000, 24'h800000, 24'h800000);
        set_idling(1);
        push_directed();
        push_random(40);
        drain();

        set_camera(MODE_ODD, 24'h800000, 24'h7FFFFF, 24'h800000,
                   24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        set_idling(2);
        push_random(45);
        drain();

        // Unit camera axes in z-axis mode, then camera mode with random axes.
        set_camera(MODE_ZAXIS, 24'h000000, 24'h000000, 24'h010000,
                   24'h000000, 24'h010000, 24'h000000);
        set_idling(3);
        push_random(45);
        drain();
        set_camera(MODE_CAMERA, rand_element(), rand_element(), rand_element(),
                   rand_element(), rand_element(), rand_element());
        set_idling(0);
        push_random(40);

        drain();
        if (errors == 0)
            $display("billboard_matrix_orient regression: pass");
        else
            $display("billboard_matrix_orient regression: fail");
        $finish;
    end

endmodule
